### src/rmm_pkg.sv
package rmm_pkg;

  localparam int ACT_W = 2;
  localparam int NODE_W = 6;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT  = 2'd0,
    ACT_LINK  = 2'd1,
    ACT_FUSE  = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    RD_FIRST  = 2'd0,
    RD_SECOND = 2'd1,
    RD_NEXT   = 2'd2,
    RD_ZERO   = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    take;
    logic    do_init;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_second;
    logic    cap_gain;
    logic    wr_link;
    logic    wr_sweep;
    logic    kill;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    bad;
    logic    sweep_last;
    logic    out_free;
  } dp_stat_t;

endpackage

### src/reachability_matrix_merge_top.sv
// Channel  Direction  Handshake                      Payload
// cfg      in         cfg_valid / cfg_ready          cfg_data: node_count
// s_axis   in         s_axis_tvalid / s_axis_tready  action, first_node, second_node
// m_axis   out        m_axis_tvalid / m_axis_tready  reachable, bad_index
//
// Init, query and flagged items go straight from the check state to the result load.
// Link reads two rows and writes one; fuse makes one pass over every row
// through the single read and single write port of the row memory.
// Reset loads node_count 64, the identity matrix and the alive mask at once.
// A new item is accepted while the previous result waits; a stalled output holds
// the controller in its finishing state until the result register frees.
module reachability_matrix_merge_top #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // action [1:0], first_node [7:2], second_node [13:8]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // reachable [0], bad_index [1]
);

  rmm_pkg::dp_cmd_t  cmd;
  rmm_pkg::dp_stat_t stat;
  logic              out_reachable;
  logic              out_bad;

  assign cfg_ready = 1'b1;

  rmm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmm_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .in_action     (s_axis_tdata[1:0]),
    .in_first      (s_axis_tdata[7:2]),
    .in_second     (s_axis_tdata[13:8]),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_reachable (out_reachable),
    .out_bad       (out_bad)
  );

  assign m_axis_tdata = {6'b0, out_bad, out_reachable};

endmodule

### src/rmm_ctrl.sv
module rmm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmm_pkg::dp_stat_t stat,
  output rmm_pkg::dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_CHECK     = 8'b0000_0010,
    ST_LINK_RD   = 8'b0000_0100,
    ST_LINK_WR   = 8'b0000_1000,
    ST_FUSE_RD   = 8'b0001_0000,
    ST_FUSE_GAIN = 8'b0010_0000,
    ST_SWEEP     = 8'b0100_0000,
    ST_FINISH    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.rd_sel = rmm_pkg::RD_FIRST;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        unique case (stat.action)
          rmm_pkg::ACT_INIT: begin
            cmd.do_init = 1'b1;
            state_next  = ST_FINISH;
          end
          rmm_pkg::ACT_LINK: begin
            if (stat.bad) begin
              state_next = ST_FINISH;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rmm_pkg::RD_SECOND;
              state_next = ST_LINK_RD;
            end
          end
          rmm_pkg::ACT_FUSE: begin
            if (stat.bad) begin
              state_next = ST_FINISH;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rmm_pkg::RD_SECOND;
              state_next = ST_FUSE_RD;
            end
          end
          rmm_pkg::ACT_QUERY: begin
            if (!stat.bad) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rmm_pkg::RD_FIRST;
            end
            state_next = ST_FINISH;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_LINK_RD: begin
        cmd.cap_second = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = rmm_pkg::RD_FIRST;
        state_next     = ST_LINK_WR;
      end
      ST_LINK_WR: begin
        cmd.wr_link = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FUSE_RD: begin
        cmd.cap_second = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = rmm_pkg::RD_FIRST;
        state_next     = ST_FUSE_GAIN;
      end
      ST_FUSE_GAIN: begin
        cmd.cap_gain = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = rmm_pkg::RD_ZERO;
        state_next   = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.wr_sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.kill   = 1'b1;
          state_next = ST_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = rmm_pkg::RD_NEXT;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_take_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_CHECK))
    else $error("Accepted item did not move to the check state.");

  a_short_path: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && (stat.action == rmm_pkg::ACT_INIT || stat.bad))
      |=> (state == ST_FINISH))
    else $error("Init or flagged item did not finish directly.");

  a_sweep_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && stat.sweep_last) |=> (state == ST_FINISH))
    else $error("Sweep did not end after the last row.");

endmodule

### src/rmm_datapath.sv
module rmm_datapath #(
  parameter int MAX_NODES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [rmm_pkg::CFG_W-1:0]        cfg_data,
  input  logic [rmm_pkg::ACT_W-1:0]        in_action,
  input  logic [rmm_pkg::NODE_W-1:0]       in_first,
  input  logic [rmm_pkg::NODE_W-1:0]       in_second,
  input  rmm_pkg::dp_cmd_t                 cmd,
  output rmm_pkg::dp_stat_t                stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_reachable,
  output logic                             out_bad
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > rmm_pkg::CFG_W) ? CNT_W : rmm_pkg::CFG_W;
  localparam int RESET_CNT = (MAX_NODES < 64) ? MAX_NODES : 64;

  logic [rmm_pkg::CFG_W-1:0]  node_count;
  logic [MAX_NODES-1:0]       alive;
  logic [MAX_NODES-1:0]       row_valid;
  logic [MAX_NODES-1:0]       mem [MAX_NODES];
  logic [MAX_NODES-1:0]       rd_data;
  logic                       rd_valid;
  logic [IDX_W-1:0]           rd_addr_q;
  rmm_pkg::action_t           action_q;
  logic [rmm_pkg::NODE_W-1:0] first_q;
  logic [rmm_pkg::NODE_W-1:0] second_q;
  logic [MAX_NODES-1:0]       second_row;
  logic [MAX_NODES-1:0]       gain_t;
  logic [MAX_NODES-1:0]       gain_o;

  logic [CMP_W-1:0]     count_ext;
  logic [CMP_W-1:0]     eff_count;
  logic                 bad;
  logic [IDX_W-1:0]     a_idx;
  logic [IDX_W-1:0]     b_idx;
  logic [IDX_W-1:0]     rd_addr;
  logic [MAX_NODES-1:0] row;
  logic [MAX_NODES-1:0] init_alive;
  logic [MAX_NODES-1:0] reset_alive;
  logic [MAX_NODES-1:0] first_gain;
  logic [MAX_NODES-1:0] sweep_row;
  logic [MAX_NODES-1:0] wr_data;
  logic                 wr_en;

  assign count_ext = CMP_W'(node_count);
  assign eff_count = (count_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : count_ext;
  assign bad = (CMP_W'(first_q) >= eff_count) || (CMP_W'(second_q) >= eff_count);
  assign a_idx = IDX_W'(first_q);
  assign b_idx = IDX_W'(second_q);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      init_alive[i]  = CMP_W'(i) < eff_count;
      reset_alive[i] = i < RESET_CNT;
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      rmm_pkg::RD_FIRST:  rd_addr = a_idx;
      rmm_pkg::RD_SECOND: rd_addr = b_idx;
      rmm_pkg::RD_NEXT:   rd_addr = rd_addr_q + IDX_W'(1);
      rmm_pkg::RD_ZERO:   rd_addr = '0;
      default:            rd_addr = '0;
    endcase
  end

  // A row never written since init reads as its identity row.
  assign row = rd_valid ? rd_data : (MAX_NODES'(1) << rd_addr_q);

  assign first_gain = alive & second_row & ~row;

  always_comb begin
    if (alive[rd_addr_q] && row[a_idx]) begin
      sweep_row = row | gain_t;
    end else if (alive[rd_addr_q] && row[b_idx]) begin
      sweep_row = row | gain_o;
    end else begin
      sweep_row = row;
    end
  end

  assign wr_en   = cmd.wr_link || cmd.wr_sweep;
  assign wr_data = cmd.wr_link ? (row | (alive & second_row)) : sweep_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr_q] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_valid  <= row_valid[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (cmd.take) begin
      action_q <= rmm_pkg::action_t'(in_action);
      first_q  <= in_first;
      second_q <= in_second;
    end
    if (cmd.cap_second) begin
      second_row <= row;
    end
    if (cmd.cap_gain) begin
      gain_t <= first_gain;
      gain_o <= alive & (row | (alive[a_idx] ? first_gain : '0));
    end
    if (cmd.load_out) begin
      out_reachable <= (action_q == rmm_pkg::ACT_QUERY) && !bad && row[b_idx];
      out_bad       <= (action_q != rmm_pkg::ACT_INIT) && bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= rmm_pkg::CFG_RESET;
      alive      <= reset_alive;
      row_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      if (cmd.do_init) begin
        alive     <= init_alive;
        row_valid <= '0;
      end else begin
        if (cmd.kill) begin
          alive[b_idx] <= 1'b0;
        end
        if (wr_en) begin
          row_valid[rd_addr_q] <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.action     = action_q;
  assign stat.bad        = bad;
  assign stat.sweep_last = rd_addr_q == IDX_W'(MAX_NODES - 1);
  assign stat.out_free   = !out_valid || out_ready;

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(cmd.rd_en))
    else $error("Row written without the read of that row one cycle earlier.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("Result loaded over a result that is still waiting.");

  a_kill_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.kill |=> !alive[$past(b_idx)])
    else $error("Fused node is still alive after the sweep.");

endmodule
